@@ rtl/euler_motion_integrator_macros.svh @@
// assertion macros shared by the checker files of the motion integrator
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef EULER_MOTION_INTEGRATOR_MACROS_SVH
`define EULER_MOTION_INTEGRATOR_MACROS_SVH

// condition holds in the same cycle as the trigger
`define EMI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define EMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/emi_pkg.sv @@
// shared types, widths, config codes and saturation helper of the motion integrator
// no dependencies
`timescale 1ns / 1ps

package emi_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned IdW      = 8;
  localparam int unsigned DtW      = 17;
  localparam int unsigned AirW     = 24;
  localparam int unsigned ThrW     = 31;
  localparam int unsigned CfgIdxW  = 3;

  localparam int unsigned AirDtW  = AirW + DtW;
  // damping factor one minus (air * dt) >> frac, signed
  localparam int unsigned DampW   = ((AirDtW - FracBits + 1 > FracBits + 1) ?
                                     (AirDtW - FracBits + 1) : (FracBits + 1)) + 1;
  localparam int unsigned DampPrW = DataW + DampW;
  localparam int unsigned StepPrW = DataW + DtW + 1;
  localparam int unsigned SqW     = 2 * DataW - 1;
  localparam int unsigned Mag2W   = SqW + 1;
  localparam int unsigned Thr2W   = 2 * ThrW;

  localparam logic [DataW-1:0] GravXRst = 32'h0000_0000;
  localparam logic [DataW-1:0] GravYRst = 32'hFFF6_3333;
  localparam logic [DataW-1:0] GravZRst = 32'h0000_0000;
  localparam logic [DtW-1:0]   DtRst    = 17'd546;
  localparam logic [AirW-1:0]  AirRst   = 24'd19661;
  localparam logic [ThrW-1:0]  ThrRst   = 31'd4915;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRAV_X,
    CFG_GRAV_Y,
    CFG_GRAV_Z,
    CFG_TIME_STEP,
    CFG_AIR_RES,
    CFG_SPEED_THR
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]   entity_id;
    logic             asleep;
    logic [DataW-1:0] pos_x;
    logic [DataW-1:0] pos_y;
    logic [DataW-1:0] pos_z;
    logic [DataW-1:0] vel_x;
    logic [DataW-1:0] vel_y;
    logic [DataW-1:0] vel_z;
    logic             last_entity;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]   out_entity_id;
    logic [DataW-1:0] new_pos_x;
    logic [DataW-1:0] new_pos_y;
    logic [DataW-1:0] new_pos_z;
    logic [DataW-1:0] new_vel_x;
    logic [DataW-1:0] new_vel_y;
    logic [DataW-1:0] new_vel_z;
    logic             snapped_to_rest;
    logic             out_last;
  } out_item_t;

  // coefficients derived from the config registers
  typedef struct packed {
    logic [2:0][DataW-1:0] gdt;
    logic [DampW-1:0]      damp;
    logic [DtW-1:0]        dt;
    logic [Thr2W-1:0]      thr2;
  } coef_t;

  function automatic logic [DataW-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      return 32'h7FFF_FFFF;
    end else if (x < lo) begin
      return 32'h8000_0000;
    end
    return x[DataW-1:0];
  endfunction

endpackage

@@ rtl/emi_cfg.sv @@
// config registers and the coefficients derived from them
// depends on emi_pkg
`timescale 1ns / 1ps

module emi_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [emi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [emi_pkg::DataW-1:0]     cfg_wdata_i,
  output emi_pkg::coef_t                coef_o
);

  logic [2:0][emi_pkg::DataW-1:0] grav_d, grav_q;
  logic [emi_pkg::DtW-1:0]        dt_d, dt_q;
  logic [emi_pkg::AirW-1:0]       air_d, air_q;
  logic [emi_pkg::ThrW-1:0]       thr_d, thr_q;
  emi_pkg::coef_t                 coef_d, coef_q;

  always_comb begin
    grav_d = grav_q;
    dt_d   = dt_q;
    air_d  = air_q;
    thr_d  = thr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        emi_pkg::CFG_GRAV_X:    grav_d[0] = cfg_wdata_i;
        emi_pkg::CFG_GRAV_Y:    grav_d[1] = cfg_wdata_i;
        emi_pkg::CFG_GRAV_Z:    grav_d[2] = cfg_wdata_i;
        emi_pkg::CFG_TIME_STEP: dt_d      = cfg_wdata_i[emi_pkg::DtW-1:0];
        emi_pkg::CFG_AIR_RES:   air_d     = cfg_wdata_i[emi_pkg::AirW-1:0];
        emi_pkg::CFG_SPEED_THR: thr_d     = cfg_wdata_i[emi_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0] <= emi_pkg::GravXRst;
      grav_q[1] <= emi_pkg::GravYRst;
      grav_q[2] <= emi_pkg::GravZRst;
      dt_q      <= emi_pkg::DtRst;
      air_q     <= emi_pkg::AirRst;
      thr_q     <= emi_pkg::ThrRst;
    end else begin
      grav_q <= grav_d;
      dt_q   <= dt_d;
      air_q  <= air_d;
      thr_q  <= thr_d;
    end
  end

  // built from the next register values so a write and its coefficients land together
  always_comb begin
    logic signed [emi_pkg::StepPrW-1:0] gprod;
    logic signed [emi_pkg::StepPrW-1:0] gsh;
    logic [emi_pkg::AirDtW-1:0]         airdt;
    logic [emi_pkg::DampW-1:0]          one_c;
    coef_d = '0;
    for (int i = 0; i < 3; i++) begin
      gprod = $signed(grav_d[i]) * $signed({1'b0, dt_d});
      gsh   = gprod >>> emi_pkg::FracBits;
      coef_d.gdt[i] = emi_pkg::sat32({{(64 - emi_pkg::StepPrW){gsh[emi_pkg::StepPrW-1]}}, gsh});
    end
    airdt  = emi_pkg::AirDtW'(air_d) * emi_pkg::AirDtW'(dt_d);
    one_c  = emi_pkg::DampW'(1) << emi_pkg::FracBits;
    coef_d.damp = one_c - emi_pkg::DampW'(airdt >> emi_pkg::FracBits);
    coef_d.dt   = dt_d;
    coef_d.thr2 = emi_pkg::Thr2W'(thr_d) * emi_pkg::Thr2W'(thr_d);
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

@@ rtl/emi_lane.sv @@
// five-stage arithmetic pipeline for one axis: gravity, damping, position, square
// depends on emi_pkg
`timescale 1ns / 1ps

module emi_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        asleep_i,
  input  logic [emi_pkg::DataW-1:0]   pos_i,
  input  logic [emi_pkg::DataW-1:0]   vel_i,
  input  logic [emi_pkg::DataW-1:0]   gdt_i,
  input  logic [emi_pkg::DampW-1:0]   damp_i,
  input  logic [emi_pkg::DtW-1:0]     dt_i,
  output logic [emi_pkg::DataW-1:0]   pos_o,
  output logic [emi_pkg::DataW-1:0]   vel_o,
  output logic [emi_pkg::SqW-1:0]     sq_o
);

  // input state carried along: sleeping items keep it, awake ones add the step to the position
  logic [3:0][emi_pkg::DataW-1:0] pos_p_q, vel_p_q;
  logic [3:0]                     slp_p_q;

  logic [emi_pkg::DataW:0]              v1_sum;
  logic [emi_pkg::DataW-1:0]            v1_d, v1_q;
  logic signed [emi_pkg::DampPrW-1:0]   pd_d, pd_q, pd_sh;
  logic [emi_pkg::DataW-1:0]            v2_d, v2_q;
  logic signed [emi_pkg::StepPrW-1:0]   vdt_d, vdt_q, vdt_sh, psum;
  logic signed [63:0]                   sq_full;
  logic [emi_pkg::SqW-1:0]              sq_d, sq4_q;
  logic [emi_pkg::DataW-1:0]            v4_q;
  logic [emi_pkg::DataW-1:0]            pos_d, vel_d, pos_q, vel_q;
  logic [emi_pkg::SqW-1:0]              sq_q;

  always_comb begin
    v1_sum  = {vel_i[emi_pkg::DataW-1], vel_i} + {gdt_i[emi_pkg::DataW-1], gdt_i};
    v1_d    = emi_pkg::sat32({{(64 - emi_pkg::DataW - 1){v1_sum[emi_pkg::DataW]}}, v1_sum});
    pd_d    = $signed(v1_q) * $signed(damp_i);
    pd_sh   = pd_q >>> emi_pkg::FracBits;
    v2_d    = emi_pkg::sat32({{(64 - emi_pkg::DampPrW){pd_sh[emi_pkg::DampPrW-1]}}, pd_sh});
    vdt_d   = $signed(v2_q) * $signed({1'b0, dt_i});
    sq_full = $signed(v2_q) * $signed(v2_q);
    sq_d    = sq_full[emi_pkg::SqW-1:0];
    vdt_sh  = vdt_q >>> emi_pkg::FracBits;
    psum    = $signed({{(emi_pkg::StepPrW - emi_pkg::DataW){pos_p_q[3][emi_pkg::DataW-1]}},
                       pos_p_q[3]}) + vdt_sh;
    pos_d   = slp_p_q[3] ? pos_p_q[3] :
              emi_pkg::sat32({{(64 - emi_pkg::StepPrW){psum[emi_pkg::StepPrW-1]}}, psum});
    vel_d   = slp_p_q[3] ? vel_p_q[3] : v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_p_q <= {pos_p_q[2:0], pos_i};
      vel_p_q <= {vel_p_q[2:0], vel_i};
      slp_p_q <= {slp_p_q[2:0], asleep_i};
      v1_q    <= v1_d;
      pd_q    <= pd_d;
      v2_q    <= v2_d;
      vdt_q   <= vdt_d;
      sq4_q   <= sq_d;
      v4_q    <= v2_q;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      sq_q    <= sq4_q;
    end
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;
  assign sq_o  = sq_q;

endmodule

@@ rtl/euler_motion_integrator.sv @@
// semi-implicit euler step, one entity per item, six register stages
// a result passes the lane registers and then the output register before it is valid
// throughput: one item per cycle; an unaccepted result freezes the whole pipeline
// depth set by the damping multiply and the step multiply, each followed by a register
// reset clears all valid bits and loads the default gravity, step, damping and threshold
`timescale 1ns / 1ps

module euler_motion_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  emi_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output emi_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [emi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [emi_pkg::DataW-1:0]     cfg_wdata_i
);

  emi_pkg::coef_t coef;

  logic                           adv;
  logic [5:0]                     vld_q;
  logic [4:0][emi_pkg::IdW-1:0]   id_p_q;
  logic [4:0]                     last_p_q;
  logic [4:0]                     slp_p_q;

  logic [2:0][emi_pkg::DataW-1:0] pos_in, vel_in, lane_pos, lane_vel;
  logic [2:0][emi_pkg::SqW-1:0]   lane_sq;
  logic [emi_pkg::Mag2W-1:0]      mag2;
  logic                           snap;
  emi_pkg::out_item_t             out_d, out_q;

  emi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  assign pos_in = {in_item_i.pos_z, in_item_i.pos_y, in_item_i.pos_x};
  assign vel_in = {in_item_i.vel_z, in_item_i.vel_y, in_item_i.vel_x};

  // whole pipeline moves unless the output holds an untaken result
  assign adv        = !vld_q[5] || out_ready_i;
  assign in_ready_o = adv;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    emi_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .asleep_i (in_item_i.asleep),
      .pos_i    (pos_in[g]),
      .vel_i    (vel_in[g]),
      .gdt_i    (coef.gdt[g]),
      .damp_i   (coef.damp),
      .dt_i     (coef.dt),
      .pos_o    (lane_pos[g]),
      .vel_o    (lane_vel[g]),
      .sq_o     (lane_sq[g])
    );
  end

  always_comb begin
    mag2 = emi_pkg::Mag2W'(lane_sq[0]) + emi_pkg::Mag2W'(lane_sq[1])
         + emi_pkg::Mag2W'(lane_sq[2]);
    // strictly below the threshold snaps to rest
    snap = !slp_p_q[4] && (mag2 < emi_pkg::Mag2W'(coef.thr2));
    out_d.out_entity_id   = id_p_q[4];
    out_d.new_pos_x       = lane_pos[0];
    out_d.new_pos_y       = lane_pos[1];
    out_d.new_pos_z       = lane_pos[2];
    out_d.new_vel_x       = snap ? '0 : lane_vel[0];
    out_d.new_vel_y       = snap ? '0 : lane_vel[1];
    out_d.new_vel_z       = snap ? '0 : lane_vel[2];
    out_d.snapped_to_rest = snap;
    out_d.out_last        = last_p_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      id_p_q   <= {id_p_q[3:0], in_item_i.entity_id};
      last_p_q <= {last_p_q[3:0], in_item_i.last_entity};
      slp_p_q  <= {slp_p_q[3:0], in_item_i.asleep};
      out_q    <= out_d;
    end
  end

  assign out_valid_o = vld_q[5];
  assign out_item_o  = out_q;

endmodule

@@ rtl/emi_checker.sv @@
// port-level checks of the motion integrator, bound to the top level
// depends on emi_pkg and euler_motion_integrator_macros.svh
`timescale 1ns / 1ps
`include "euler_motion_integrator_macros.svh"

module emi_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  emi_pkg::out_item_t out_item_i
);

  `EMI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "stalled result changed or dropped")
  `EMI_ASSERT_SAME(a_ready_when_empty, !out_valid_i, in_ready_i, "input blocked with empty output")
  `EMI_ASSERT_SAME(a_stall_blocks_input, out_valid_i && !out_ready_i && in_valid_i, !in_ready_i, "item taken while pipeline stalled")
  `EMI_ASSERT_SAME(a_snap_zero, out_valid_i && out_item_i.snapped_to_rest, out_item_i.new_vel_x == '0 && out_item_i.new_vel_y == '0 && out_item_i.new_vel_z == '0, "snapped item with nonzero velocity")

endmodule

bind euler_motion_integrator emi_checker u_emi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

@@ bench/testbench.sv @@
// self-checking bench for euler_motion_integrator: streams entities under several register
// settings and compares every result against an in-bench fixed-point integrator
// depends on emi_pkg and the euler_motion_integrator rtl
`timescale 1ns / 1ps

module testbench;

  localparam logic [emi_pkg::CfgIdxW-1:0] CfgIdxSpareA = 3'd6;
  localparam logic [emi_pkg::CfgIdxW-1:0] CfgIdxSpareB = 3'd7;
  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems = 195;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  emi_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  emi_pkg::out_item_t out_item_o;
  logic cfg_we_i;
  logic [emi_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [emi_pkg::DataW-1:0] cfg_wdata_i;

  // bench copy of the register file
  logic [emi_pkg::DataW-1:0] grav_reg [3];
  logic [emi_pkg::DtW-1:0] dt_reg;
  logic [emi_pkg::AirW-1:0] air_reg;
  logic [emi_pkg::ThrW-1:0] thr_reg;

  emi_pkg::in_item_t pending_entities[$];
  emi_pkg::out_item_t expected_motion[$];
  emi_pkg::out_item_t motion_want;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit item_taken = 1'b0;
  bit hold_sender = 1'b0;
  int unsigned gap_left = 0;
  int unsigned send_run = 0;
  bit send_calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned recv_run = 0;
  bit recv_calm = 1'b0;

  euler_motion_integrator uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint signed limit_to_word(longint signed x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // one semi-implicit euler step at the current register settings
  function automatic emi_pkg::out_item_t integrate_entity(emi_pkg::in_item_t it);
    emi_pkg::out_item_t r;
    longint signed p [3];
    longint signed v [3];
    longint signed g [3];
    longint signed step;
    longint signed air;
    longint signed one;
    longint signed damp;
    longint signed dv;
    longint unsigned a;
    longint unsigned mag2;
    longint unsigned thr;
    p[0] = $signed(it.pos_x);
    p[1] = $signed(it.pos_y);
    p[2] = $signed(it.pos_z);
    v[0] = $signed(it.vel_x);
    v[1] = $signed(it.vel_y);
    v[2] = $signed(it.vel_z);
    for (int i = 0; i < 3; i++) g[i] = $signed(grav_reg[i]);
    step = dt_reg;
    air = air_reg;
    thr = thr_reg;
    one = longint'(1) <<< emi_pkg::FracBits;
    r.snapped_to_rest = 1'b0;
    if (!it.asleep) begin
      damp = one - ((air * step) >>> emi_pkg::FracBits);
      mag2 = 0;
      for (int i = 0; i < 3; i++) begin
        dv = limit_to_word((g[i] * step) >>> emi_pkg::FracBits);
        v[i] = limit_to_word(v[i] + dv);
        v[i] = limit_to_word((v[i] * damp) >>> emi_pkg::FracBits);
        p[i] = limit_to_word(p[i] + ((v[i] * step) >>> emi_pkg::FracBits));
      end
      for (int i = 0; i < 3; i++) begin
        a = (v[i] < 0) ? -v[i] : v[i];
        mag2 += a * a;
      end
      // only strictly below the threshold comes to rest
      if (mag2 < thr * thr) begin
        v[0] = 0;
        v[1] = 0;
        v[2] = 0;
        r.snapped_to_rest = 1'b1;
      end
    end
    r.out_entity_id = it.entity_id;
    r.new_pos_x = 32'(p[0]);
    r.new_pos_y = 32'(p[1]);
    r.new_pos_z = 32'(p[2]);
    r.new_vel_x = 32'(v[0]);
    r.new_vel_y = 32'(v[1]);
    r.new_vel_z = 32'(v[2]);
    r.out_last = it.last_entity;
    return r;
  endfunction

  function automatic logic [emi_pkg::DataW-1:0] near_threshold();
    int unsigned span;
    span = (thr_reg > 31'd1048576) ? 1048576 : int'(thr_reg);
    if (span < 16) span = 16;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // small velocity that roughly cancels this step's gravity, so that rest is reachable
  function automatic logic [emi_pkg::DataW-1:0] rest_velocity(int axis);
    longint signed step;
    longint signed gd;
    step = dt_reg;
    gd = ($signed(grav_reg[axis]) * step) >>> emi_pkg::FracBits;
    return 32'($signed(near_threshold()) - gd);
  endfunction

  function automatic logic [emi_pkg::DataW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      4, 5, 6: return $urandom_range(0, 2 ** 21) - 2 ** 20;
      default: return near_threshold();
    endcase
  endfunction

  function automatic emi_pkg::in_item_t rand_entity();
    emi_pkg::in_item_t it;
    it.entity_id = 8'($urandom_range(0, 255));
    it.asleep = ($urandom_range(0, 7) == 0);
    it.last_entity = ($urandom_range(0, 9) == 0);
    it.pos_x = rand_word();
    it.pos_y = rand_word();
    it.pos_z = rand_word();
    if ($urandom_range(0, 2) == 0) begin
      it.vel_x = rest_velocity(0);
      it.vel_y = rest_velocity(1);
      it.vel_z = rest_velocity(2);
    end else begin
      it.vel_x = rand_word();
      it.vel_y = rand_word();
      it.vel_z = rand_word();
    end
    return it;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic add_entity(input logic [emi_pkg::IdW-1:0] id, input logic asleep,
                            input logic [emi_pkg::DataW-1:0] px,
                            input logic [emi_pkg::DataW-1:0] py,
                            input logic [emi_pkg::DataW-1:0] pz,
                            input logic [emi_pkg::DataW-1:0] vx,
                            input logic [emi_pkg::DataW-1:0] vy,
                            input logic [emi_pkg::DataW-1:0] vz,
                            input logic last);
    emi_pkg::in_item_t it;
    it = '{entity_id: id, asleep: asleep, pos_x: px, pos_y: py, pos_z: pz,
           vel_x: vx, vel_y: vy, vel_z: vz, last_entity: last};
    pending_entities.push_back(it);
  endtask

  task automatic set_reg(input logic [emi_pkg::CfgIdxW-1:0] idx,
                         input logic [emi_pkg::DataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      emi_pkg::CFG_GRAV_X: grav_reg[0] = value;
      emi_pkg::CFG_GRAV_Y: grav_reg[1] = value;
      emi_pkg::CFG_GRAV_Z: grav_reg[2] = value;
      emi_pkg::CFG_TIME_STEP: dt_reg = value[emi_pkg::DtW-1:0];
      emi_pkg::CFG_AIR_RES: air_reg = value[emi_pkg::AirW-1:0];
      emi_pkg::CFG_SPEED_THR: thr_reg = value[emi_pkg::ThrW-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input int kind);
    logic [emi_pkg::DataW-1:0] g [3];
    logic [emi_pkg::DataW-1:0] dt;
    logic [emi_pkg::DataW-1:0] air;
    logic [emi_pkg::DataW-1:0] thr;
    case (kind)
      0: begin
        for (int i = 0; i < 3; i++) g[i] = $urandom_range(0, 1400000) - 700000;
        dt = $urandom_range(1, 4096);
        air = $urandom_range(0, 200000);
        thr = $urandom_range(0, 40000);
      end
      1: begin
        for (int i = 0; i < 3; i++) g[i] = $urandom;
        dt = $urandom;
        air = $urandom;
        thr = $urandom;
      end
      2: begin
        g[0] = 32'h7FFF_FFFF;
        g[1] = 32'h8000_0000;
        g[2] = 32'h7FFF_FFFF;
        dt = 32'hFFFF_FFFF;
        air = 32'hFFFF_FFFF;
        thr = 32'hFFFF_FFFF;
      end
      3: begin
        for (int i = 0; i < 3; i++) g[i] = '0;
        dt = '0;
        air = '0;
        thr = '0;
      end
      default: begin
        for (int i = 0; i < 3; i++) g[i] = $urandom_range(0, 1400000) - 700000;
        dt = $urandom_range(0, 65536);
        air = '0;
        thr = $urandom_range(0, 2000000);
      end
    endcase
    set_reg(emi_pkg::CFG_GRAV_X, g[0]);
    set_reg(emi_pkg::CFG_GRAV_Y, g[1]);
    set_reg(emi_pkg::CFG_GRAV_Z, g[2]);
    set_reg(emi_pkg::CFG_TIME_STEP, dt);
    set_reg(emi_pkg::CFG_AIR_RES, air);
    set_reg(emi_pkg::CFG_SPEED_THR, thr);
    // unmapped index must leave every register alone
    set_reg(($urandom_range(0, 1) == 0) ? CfgIdxSpareA : CfgIdxSpareB, $urandom);
    end_writes();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_entities.size() != 0 || in_valid_i || expected_motion.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t error: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_word(input string name, input logic [emi_pkg::DataW-1:0] got,
                            input logic [emi_pkg::DataW-1:0] want,
                            input logic [emi_pkg::IdW-1:0] id);
    if (got !== want)
      report_mismatch($sformatf("entity %0d %s got %h expected %h", id, name, got, want));
  endtask

  // sender: a new item goes out once the last one is taken and its gap has run out
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (send_run == 0) begin
        send_run = $urandom_range(20, 150);
        send_calm = ($urandom_range(0, 3) == 0);
      end
      send_run--;
      if (!in_valid_i || item_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_entities.size() != 0 && !hold_sender) begin
          in_item_i <= pending_entities.pop_front();
          in_valid_i <= 1'b1;
          gap_left = send_calm ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
    item_taken = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_run == 0) begin
        recv_run = $urandom_range(20, 150);
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      recv_run--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = recv_calm ? 0 : idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_motion.size() == 0) begin
          report_mismatch($sformatf("unexpected result for entity %0d",
                                    out_item_o.out_entity_id));
        end else begin
          motion_want = expected_motion.pop_front();
          check_word("out_entity_id", emi_pkg::DataW'(out_item_o.out_entity_id),
                     emi_pkg::DataW'(motion_want.out_entity_id),
                     motion_want.out_entity_id);
          check_word("new_pos_x", out_item_o.new_pos_x, motion_want.new_pos_x,
                     motion_want.out_entity_id);
          check_word("new_pos_y", out_item_o.new_pos_y, motion_want.new_pos_y,
                     motion_want.out_entity_id);
          check_word("new_pos_z", out_item_o.new_pos_z, motion_want.new_pos_z,
                     motion_want.out_entity_id);
          check_word("new_vel_x", out_item_o.new_vel_x, motion_want.new_vel_x,
                     motion_want.out_entity_id);
          check_word("new_vel_y", out_item_o.new_vel_y, motion_want.new_vel_y,
                     motion_want.out_entity_id);
          check_word("new_vel_z", out_item_o.new_vel_z, motion_want.new_vel_z,
                     motion_want.out_entity_id);
          check_word("snapped_to_rest", emi_pkg::DataW'(out_item_o.snapped_to_rest),
                     emi_pkg::DataW'(motion_want.snapped_to_rest),
                     motion_want.out_entity_id);
          check_word("out_last", emi_pkg::DataW'(out_item_o.out_last),
                     emi_pkg::DataW'(motion_want.out_last), motion_want.out_entity_id);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_motion.push_back(integrate_entity(in_item_i));
        item_taken = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    grav_reg[0] = emi_pkg::GravXRst;
    grav_reg[1] = emi_pkg::GravYRst;
    grav_reg[2] = emi_pkg::GravZRst;
    dt_reg = emi_pkg::DtRst;
    air_reg = emi_pkg::AirRst;
    thr_reg = emi_pkg::ThrRst;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: field extremes, sleeping entities, one that comes to rest
    add_entity(8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_entity(8'hFF, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_entity(8'h01, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_entity(8'hAA, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    add_entity(8'h55, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_entity(8'h10, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
               32'd10, 32'd5351, -32'sd10, 1'b0);
    add_entity(8'h11, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_entity(8'h12, 1'b0, 32'h7FFF_0000, 32'h8000_FFFF, 32'h0,
               32'h4000_0000, -32'sd1073741824, 32'd6000, 1'b0);
    wait_drained();

    // no time step: speed at the threshold stays, one below comes to rest
    set_reg(emi_pkg::CFG_TIME_STEP, 32'd0);
    set_reg(emi_pkg::CFG_SPEED_THR, 32'd1000);
    end_writes();
    add_entity(8'h20, 1'b0, 32'h1234_5678, 32'h0, 32'h0, 32'd1000, 32'd0, 32'd0, 1'b0);
    add_entity(8'h21, 1'b0, 32'h0, 32'h0, 32'h0, 32'd999, 32'd0, 32'd0, 1'b0);
    add_entity(8'h22, 1'b0, 32'h0, 32'h0, 32'h0, 32'd600, 32'd800, 32'd0, 1'b0);
    add_entity(8'h23, 1'b0, 32'h0, 32'h0, 32'h0, 32'd600, 32'd799, 32'd0, 1'b0);
    add_entity(8'h24, 1'b0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd0, -32'sd1000, 1'b1);
    add_entity(8'h25, 1'b1, 32'h0, 32'h0, 32'h0, 32'd0, 32'd0, 32'd0, 1'b0);
    wait_drained();

    // widest registers: damping factor far below zero, everything saturates
    apply_setting(2);
    add_entity(8'h30, 1'b0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 1'b0);
    add_entity(8'h31, 1'b0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 1'b0);
    add_entity(8'h32, 1'b0, 32'h0, 32'h0, 32'h0, 32'd3, -32'sd7, 32'd1, 1'b0);
    add_entity(8'h33, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0,
               1'b1);
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      apply_setting(ph % 5);
      for (int n = 0; n < PhaseItems; n++) pending_entities.push_back(rand_entity());
      if (ph == 3) begin
        // stop sending midway until the pipeline has emptied
        while (pending_entities.size() > PhaseItems / 2) @(negedge clk_i);
        hold_sender = 1'b1;
        @(negedge clk_i);
        while (in_valid_i || expected_motion.size() != 0) @(negedge clk_i);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/emi_pkg.sv
rtl/emi_cfg.sv
rtl/emi_lane.sv
rtl/euler_motion_integrator.sv
rtl/emi_checker.sv
bench/testbench.sv
